>>> rtl/core/bsu_pkg.sv
// Shared types and constants for the bistable synapse update block.
package bsu_pkg;

	// Sizes of the synapse table and efficacy index range
	localparam int SynapseCount  = 1024;
	localparam int AddrW         = $clog2(SynapseCount);
	localparam int EfficacyDepth = 256;
	localparam int EffW          = 8;
	localparam int HiddenW       = 16;
	localparam int IntervalW     = 20;
	localparam int ProdW         = HiddenW + IntervalW;
	localparam int DriftShift    = 8;

	// Jump rule: 0 jump up when the post measure is above the threshold, 1 jump up when below it
	localparam int RuleMode = 0;

	// Configuration register indexes
	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] RegStateThreshold = 3'd0;
	localparam logic [CfgIdxW-1:0] RegFallRate       = 3'd1;
	localparam logic [CfgIdxW-1:0] RegRiseRate       = 3'd2;
	localparam logic [CfgIdxW-1:0] RegJumpUpSize     = 3'd3;
	localparam logic [CfgIdxW-1:0] RegJumpDownSize   = 3'd4;
	localparam logic [CfgIdxW-1:0] RegUpperBarrier   = 3'd5;
	localparam logic [CfgIdxW-1:0] RegLowerBarrier   = 3'd6;
	localparam logic [CfgIdxW-1:0] RegJumpThreshold  = 3'd7;

	// Operation codes
	localparam logic OpSpike = 1'b0;
	localparam logic OpInit  = 1'b1;

	// Transition codes
	localparam logic [1:0] TransNone     = 2'd0;
	localparam logic [1:0] TransPotUp    = 2'd1;
	localparam logic [1:0] TransDepDown  = 2'd2;

	typedef struct packed {
		logic                    opcode;
		logic [9:0]              synapse_index;
		logic [IntervalW-1:0]    spike_interval;
		logic signed [15:0]      post_measure;
		logic                    init_potentiated;
		logic [EffW-1:0]         init_low_index;
		logic [EffW-1:0]         init_high_index;
	} request_t;

	typedef struct packed {
		logic [9:0]              result_index;
		logic                    potentiated;
		logic [EffW-1:0]         efficacy_index;
		logic [1:0]              transition;
		logic [HiddenW-1:0]      hidden_value;
	} result_t;

	typedef struct packed {
		logic [HiddenW-1:0]      state_threshold;
		logic [HiddenW-1:0]      fall_rate;
		logic [HiddenW-1:0]      rise_rate;
		logic [HiddenW-1:0]      jump_up_size;
		logic [HiddenW-1:0]      jump_down_size;
		logic [HiddenW-1:0]      upper_barrier;
		logic [HiddenW-1:0]      lower_barrier;
		logic signed [15:0]      jump_threshold;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic read;
		logic mult;
		logic drift;
		logic jump;
		logic init;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_init;
	} status_t;

endpackage

>>> rtl/core/bsu_cfg.sv
// Configuration register file of the bistable synapse update block.
module bsu_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsu_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [15:0]                   cfg_data,
	output bsu_pkg::cfg_t                 cfg
);

	bsu_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Load the addressed register on each write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.state_threshold <= 16'd32768;
			cfg_q.fall_rate       <= 16'd256;
			cfg_q.rise_rate       <= 16'd256;
			cfg_q.jump_up_size    <= 16'd4096;
			cfg_q.jump_down_size  <= 16'd4096;
			cfg_q.upper_barrier   <= 16'd65535;
			cfg_q.lower_barrier   <= 16'd0;
			cfg_q.jump_threshold  <= 16'sd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bsu_pkg::RegStateThreshold: cfg_q.state_threshold <= cfg_data;
				bsu_pkg::RegFallRate:       cfg_q.fall_rate       <= cfg_data;
				bsu_pkg::RegRiseRate:       cfg_q.rise_rate       <= cfg_data;
				bsu_pkg::RegJumpUpSize:     cfg_q.jump_up_size    <= cfg_data;
				bsu_pkg::RegJumpDownSize:   cfg_q.jump_down_size  <= cfg_data;
				bsu_pkg::RegUpperBarrier:   cfg_q.upper_barrier   <= cfg_data;
				bsu_pkg::RegLowerBarrier:   cfg_q.lower_barrier   <= cfg_data;
				bsu_pkg::RegJumpThreshold:  cfg_q.jump_threshold  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/bsu_ctrl.sv
// Sequencing state machine for one synapse transaction.
module bsu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              result_valid,
	output bsu_pkg::cmd_t     cmd,
	input  bsu_pkg::status_t  status
);

	typedef enum logic [2:0] {
		StIdle,
		StRead,
		StMult,
		StDrift,
		StJump,
		StInit
	} state_t;

	state_t state_q;
	logic   result_valid_q;

	assign busy         = (state_q != StIdle);
	assign result_valid = result_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd.capture = (state_q == StIdle) && start;
		cmd.read    = (state_q == StRead);
		cmd.mult    = (state_q == StMult);
		cmd.drift   = (state_q == StDrift);
		cmd.jump    = (state_q == StJump);
		cmd.init    = (state_q == StInit);
	end

	// Advance state and raise the result strobe after the final step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= StIdle;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				StIdle:  if (start) state_q <= StRead;
				StRead:  state_q <= status.is_init ? StInit : StMult;
				StMult:  state_q <= StDrift;
				StDrift: state_q <= StJump;
				StJump: begin
					state_q        <= StIdle;
					result_valid_q <= 1'b1;
				end
				StInit: begin
					state_q        <= StIdle;
					result_valid_q <= 1'b1;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

endmodule

>>> rtl/core/bsu_dp.sv
// Datapath: synapse table, drift multiplier, clamping and result register.
module bsu_dp (
	input  logic                clk,
	input  bsu_pkg::request_t   request,
	input  bsu_pkg::cfg_t       cfg,
	input  bsu_pkg::cmd_t       cmd,
	output bsu_pkg::status_t    status,
	output bsu_pkg::result_t    result
);

	localparam int EntryW = bsu_pkg::HiddenW + 2 * bsu_pkg::EffW;
	localparam int WideW  = bsu_pkg::HiddenW + 2;

	typedef struct packed {
		logic [bsu_pkg::HiddenW-1:0] hidden;
		logic [bsu_pkg::EffW-1:0]    low_idx;
		logic [bsu_pkg::EffW-1:0]    high_idx;
	} entry_t;

	logic [EntryW-1:0]              mem [bsu_pkg::SynapseCount];
	bsu_pkg::request_t              req_q;
	entry_t                         rd_q;
	logic [bsu_pkg::ProdW-1:0]      prod_q;
	logic                           before_q;
	logic                           up_q;
	logic [bsu_pkg::HiddenW-1:0]    h1_q;
	bsu_pkg::result_t               result_q;

	logic [bsu_pkg::AddrW-1:0]      addr;
	logic                           before_c;
	logic                           up_c;
	logic [bsu_pkg::HiddenW-1:0]    drift_c;
	logic [bsu_pkg::HiddenW-1:0]    h1_c;
	logic [bsu_pkg::HiddenW-1:0]    h2_c;
	logic                           after_c;
	logic [1:0]                     trans_c;
	logic [bsu_pkg::HiddenW-1:0]    init_h_c;
	logic [bsu_pkg::EffW-1:0]       init_lo_c;
	logic [bsu_pkg::EffW-1:0]       init_hi_c;
	logic                           init_after_c;
	logic                           mem_we;
	entry_t                         mem_wdata;

	// Add and pull down to the upper barrier if above it
	function automatic logic [bsu_pkg::HiddenW-1:0] rise_clamp(
		input logic [bsu_pkg::HiddenW-1:0] h,
		input logic [bsu_pkg::HiddenW-1:0] amount,
		input logic [bsu_pkg::HiddenW-1:0] upper
	);
		logic [WideW-1:0] sum;
		sum = WideW'(h) + WideW'(amount);
		return (sum > WideW'(upper)) ? upper : sum[bsu_pkg::HiddenW-1:0];
	endfunction

	// Subtract and lift to the lower barrier if below it
	function automatic logic [bsu_pkg::HiddenW-1:0] fall_clamp(
		input logic [bsu_pkg::HiddenW-1:0] h,
		input logic [bsu_pkg::HiddenW-1:0] amount,
		input logic [bsu_pkg::HiddenW-1:0] lower
	);
		logic signed [WideW-1:0] diff;
		diff = $signed(WideW'(h)) - $signed(WideW'(amount));
		return (diff < $signed(WideW'(lower))) ? lower : diff[bsu_pkg::HiddenW-1:0];
	endfunction

	// Saturate an efficacy index to the table depth
	function automatic logic [bsu_pkg::EffW-1:0] clamp_eff(input logic [bsu_pkg::EffW-1:0] v);
		logic [bsu_pkg::EffW-1:0] lim;
		lim = bsu_pkg::EffW'(bsu_pkg::EfficacyDepth - 1);
		if (bsu_pkg::EfficacyDepth - 1 < (1 << bsu_pkg::EffW) - 1 && v > lim) begin
			return lim;
		end
		return v;
	endfunction

	assign addr           = req_q.synapse_index[bsu_pkg::AddrW-1:0];
	assign status.is_init = (req_q.opcode == bsu_pkg::OpInit);
	assign result         = result_q;

	// Stable state before the drift and the jump direction
	always_comb begin
		before_c = rd_q.hidden > cfg.state_threshold;
		if (bsu_pkg::RuleMode == 0) begin
			up_c = req_q.post_measure > cfg.jump_threshold;
		end else begin
			up_c = req_q.post_measure < cfg.jump_threshold;
		end
	end

	// Saturate the drift term and apply it toward the matching barrier
	always_comb begin
		drift_c = (|prod_q[bsu_pkg::ProdW-1:bsu_pkg::HiddenW + bsu_pkg::DriftShift])
			? '1 : prod_q[bsu_pkg::HiddenW + bsu_pkg::DriftShift - 1:bsu_pkg::DriftShift];
		h1_c = before_q ? rise_clamp(rd_q.hidden, drift_c, cfg.upper_barrier)
			: fall_clamp(rd_q.hidden, drift_c, cfg.lower_barrier);
	end

	// Jump, then classify the transition
	always_comb begin
		h2_c = up_q ? rise_clamp(h1_q, cfg.jump_up_size, cfg.upper_barrier)
			: fall_clamp(h1_q, cfg.jump_down_size, cfg.lower_barrier);
		after_c = h2_c > cfg.state_threshold;
		priority if (!before_q && after_c) begin
			trans_c = bsu_pkg::TransPotUp;
		end else if (before_q && !after_c) begin
			trans_c = bsu_pkg::TransDepDown;
		end else begin
			trans_c = bsu_pkg::TransNone;
		end
	end

	// Initial values of a fresh entry
	always_comb begin
		init_h_c     = req_q.init_potentiated ? cfg.upper_barrier : cfg.lower_barrier;
		init_lo_c    = clamp_eff(req_q.init_low_index);
		init_hi_c    = clamp_eff(req_q.init_high_index);
		init_after_c = init_h_c > cfg.state_threshold;
	end

	// Select the write-back entry
	always_comb begin
		mem_we = cmd.jump || cmd.init;
		if (cmd.init) begin
			mem_wdata = '{hidden: init_h_c, low_idx: init_lo_c, high_idx: init_hi_c};
		end else begin
			mem_wdata = '{hidden: h2_c, low_idx: rd_q.low_idx, high_idx: rd_q.high_idx};
		end
	end

	// Synapse table: one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= mem_wdata;
		end
		if (cmd.read) begin
			rd_q <= mem[addr];
		end
	end

	// Hold the request and the intermediate values between steps
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
		end
		if (cmd.mult) begin
			before_q <= before_c;
			up_q     <= up_c;
			prod_q   <= bsu_pkg::ProdW'(before_c ? cfg.rise_rate : cfg.fall_rate)
				* bsu_pkg::ProdW'(req_q.spike_interval);
		end
		if (cmd.drift) begin
			h1_q <= h1_c;
		end
	end

	// Load the result of the finished transaction
	always_ff @(posedge clk) begin
		if (cmd.jump) begin
			result_q.result_index   <= req_q.synapse_index;
			result_q.potentiated    <= after_c;
			result_q.efficacy_index <= after_c ? rd_q.high_idx : rd_q.low_idx;
			result_q.transition     <= trans_c;
			result_q.hidden_value   <= h2_c;
		end else if (cmd.init) begin
			result_q.result_index   <= req_q.synapse_index;
			result_q.potentiated    <= init_after_c;
			result_q.efficacy_index <= init_after_c ? init_hi_c : init_lo_c;
			result_q.transition     <= bsu_pkg::TransNone;
			result_q.hidden_value   <= init_h_c;
		end
	end

endmodule

>>> rtl/core/bistable_synapse_update.sv
// Top level of the bistable synapse update block.
//
//  channel   handshake               payload                   notes
//  request   start, busy             request (request_t)       taken when start && !busy
//  result    result_valid            result (result_t)         one-cycle strobe, no stall
//  config    cfg_valid, cfg_ready    cfg_index, cfg_data       ready always high
//
// A spike update runs from the accepting edge to the result strobe through these steps:
// table read, drift multiply, drift clamp, jump clamp with write-back, strobe.
// An initialise runs through: table read with opcode decode, table write, strobe.
// busy drops in the strobe cycle, so a new transaction may be started while the
// result is shown. The receiver cannot stall the result.
// Reset clears the controller and loads register defaults; the synapse table
// is not cleared and an entry must be initialised before it is updated.
module bistable_synapse_update (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  bsu_pkg::request_t             request,
	output logic                          result_valid,
	output bsu_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsu_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [15:0]                   cfg_data
);

	bsu_pkg::cfg_t    cfg;
	bsu_pkg::cmd_t    cmd;
	bsu_pkg::status_t status;

	bsu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bsu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.result_valid (result_valid),
		.cmd          (cmd),
		.status       (status)
	);

	bsu_dp u_dp (
		.clk     (clk),
		.request (request),
		.cfg     (cfg),
		.cmd     (cmd),
		.status  (status),
		.result  (result)
	);

endmodule
